FILE: design/tcs_pkg.sv
// Shared types and constants for the camera trigger timestamp matcher.
// Used by tcs_csr, tcs_queue, tcs_stamp and camera_trigger_timestamp_sync.
package tcs_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int TIME_W = 63;
   localparam int SEQ_W = 32;
   localparam int EXP_W = 24;
   localparam int OFFSET_W = 32;
   localparam int HALF_EXP_W = 33;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 4;

   localparam logic [HALF_EXP_W-1:0] NS_PER_HALF_US = HALF_EXP_W'(500);

   localparam logic REQ_TRIGGER = 1'b0;
   localparam logic REQ_FRAME = 1'b1;

   localparam logic [1:0] CSR_EXPOSURE = 2'd0;
   localparam logic [1:0] CSR_OFFSET_LEFT = 2'd1;
   localparam logic [1:0] CSR_OFFSET_RIGHT = 2'd2;

   typedef enum logic [2:0] {
      ST_STORED = 3'd0,
      ST_OVERFLOW = 3'd1,
      ST_STAMPED = 3'd2,
      ST_OUT_OF_SYNC = 3'd3,
      ST_NO_TRIGGER = 3'd4
   } tcs_status_type;

   typedef struct packed {
      logic [HALF_EXP_W-1:0] half_exp;
      logic [OFFSET_W-1:0] offset_left;
      logic [OFFSET_W-1:0] offset_right;
   } tcs_cfg_type;

   typedef struct packed {
      logic push;
      logic pop;
   } tcs_queue_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } tcs_queue_stat_type;

endpackage

FILE: design/tcs_csr.sv
// Configuration registers (exposure, left and right offsets) on an APB-style port.
// Depends on tcs_pkg; keeps half the exposure in nanoseconds ready for the stamp adders.
module tcs_csr
   import tcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output tcs_cfg_type       cfg
);

   logic [EXP_W-1:0] exposure_ff;
   logic [HALF_EXP_W-1:0] half_exp_ff;
   logic [OFFSET_W-1:0] offset_left_ff;
   logic [OFFSET_W-1:0] offset_right_ff;
   logic [1:0] reg_index;
   logic write_en;

   assign reg_index = paddr[3:2];
   assign write_en = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         exposure_ff <= '0;
         half_exp_ff <= '0;
         offset_left_ff <= '0;
         offset_right_ff <= '0;
      end else if (write_en) begin
         case (reg_index)
            CSR_EXPOSURE: begin
               exposure_ff <= pwdata[EXP_W-1:0];
               half_exp_ff <= HALF_EXP_W'(pwdata[EXP_W-1:0]) * NS_PER_HALF_US;
            end
            CSR_OFFSET_LEFT: offset_left_ff <= pwdata[OFFSET_W-1:0];
            CSR_OFFSET_RIGHT: offset_right_ff <= pwdata[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         CSR_EXPOSURE: prdata = DATA_W'(exposure_ff);
         CSR_OFFSET_LEFT: prdata = offset_left_ff;
         CSR_OFFSET_RIGHT: prdata = offset_right_ff;
         default: prdata = '0;
      endcase
   end

   assign cfg.half_exp = half_exp_ff;
   assign cfg.offset_left = offset_left_ff;
   assign cfg.offset_right = offset_right_ff;

endmodule

FILE: design/tcs_queue.sv
// Ring queue of trigger requests (time and sequence) with a registered head read.
// Depends on tcs_pkg; one slot stays free to tell full from empty.
module tcs_queue
   import tcs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  tcs_queue_ctl_type  ctl,
   input  logic [TIME_W-1:0]  push_time,
   input  logic [SEQ_W-1:0]   push_seq,
   output tcs_queue_stat_type stat,
   output logic [TIME_W-1:0]  head_time,
   output logic [SEQ_W-1:0]   head_seq
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
   localparam int ENTRY_W = TIME_W + SEQ_W;

   logic [ENTRY_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] head_ff;
   logic [AW-1:0] rd_ptr_ff;
   logic [AW-1:0] wr_ptr_ff;
   logic [AW-1:0] rd_ptr_in;
   logic [AW-1:0] wr_ptr_in;
   logic [AW-1:0] rd_step;
   logic [AW-1:0] wr_step;
   logic [ENTRY_W-1:0] push_entry;

   assign rd_step = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + AW'(1);
   assign wr_step = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + AW'(1);
   assign rd_ptr_in = ctl.pop ? rd_step : rd_ptr_ff;
   assign wr_ptr_in = ctl.push ? wr_step : wr_ptr_ff;
   assign push_entry = {push_time, push_seq};

   assign stat.empty = (rd_ptr_ff == wr_ptr_ff);
   assign stat.full = (wr_step == rd_ptr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // forward a request written into the slot the head moves to
   always_ff @(posedge clock) begin
      if (ctl.push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= push_entry;
      end else begin
         head_ff <= mem_ff[rd_ptr_in];
      end
   end

   assign head_time = head_ff[ENTRY_W-1:SEQ_W];
   assign head_seq = head_ff[SEQ_W-1:0];

endmodule

FILE: design/tcs_stamp.sv
// Image stamp: trigger time plus half exposure plus signed camera offset, saturated.
// Depends on tcs_pkg for field widths.
module tcs_stamp
   import tcs_pkg::*;
(
   input  logic [TIME_W-1:0]     trig_time,
   input  logic [HALF_EXP_W-1:0] half_exp,
   input  logic [OFFSET_W-1:0]   offset,
   output logic [TIME_W-1:0]     stamp
);

   localparam int SUM_W = TIME_W + 2;

   logic [SUM_W-1:0] sum;

   assign sum = SUM_W'(trig_time) + SUM_W'(half_exp)
              + {{(SUM_W-OFFSET_W){offset[OFFSET_W-1]}}, offset};

   always_comb begin
      if (sum[SUM_W-1]) begin
         stamp = '0;
      end else if (sum[SUM_W-2]) begin
         stamp = '1;
      end else begin
         stamp = sum[TIME_W-1:0];
      end
   end

endmodule

FILE: design/camera_trigger_timestamp_sync.sv
// A request is registered at the input, its result in the output registers.
// Throughput: one request per cycle unless the result stalls; set by the single request
// register and the queue head. A stalled result holds the request register;
// stall reaches the request side in that case. Reset (synchronous) clears the queue
// pointers, the expected sequence, the CSRs and both valid flags, not the queue contents.
module camera_trigger_timestamp_sync
   import tcs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [TIME_W-1:0] req_trig_time,
   input  logic [SEQ_W-1:0]  req_trig_seq,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [TIME_W-1:0] rsp_stamp_left,
   output logic [TIME_W-1:0] rsp_stamp_right,
   output logic [SEQ_W-1:0]  rsp_expected_seq,
   output logic [SEQ_W-1:0]  rsp_head_seq,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   tcs_cfg_type cfg;
   tcs_queue_ctl_type q_ctl;
   tcs_queue_stat_type q_stat;
   logic [TIME_W-1:0] q_head_time;
   logic [SEQ_W-1:0] q_head_seq;

   logic in_valid_ff;
   logic in_type_ff;
   logic [TIME_W-1:0] in_time_ff;
   logic [SEQ_W-1:0] in_seq_ff;

   logic out_valid_ff;
   tcs_status_type status_ff;
   logic [TIME_W-1:0] stamp_left_ff;
   logic [TIME_W-1:0] stamp_right_ff;
   logic [SEQ_W-1:0] expected_ff;
   logic [SEQ_W-1:0] head_ff;

   logic [SEQ_W-1:0] next_exp_ff;
   logic [SEQ_W-1:0] next_exp_in;

   tcs_status_type status_in;
   logic [TIME_W-1:0] stamp_left_in;
   logic [TIME_W-1:0] stamp_right_in;
   logic [SEQ_W-1:0] expected_in;
   logic [SEQ_W-1:0] head_in;
   logic [TIME_W-1:0] calc_left;
   logic [TIME_W-1:0] calc_right;

   logic advance;
   logic fire;

   tcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tcs_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (q_ctl),
      .push_time (in_time_ff),
      .push_seq  (in_seq_ff),
      .stat      (q_stat),
      .head_time (q_head_time),
      .head_seq  (q_head_seq)
   );

   tcs_stamp u_stamp_left (
      .trig_time (q_head_time),
      .half_exp  (cfg.half_exp),
      .offset    (cfg.offset_left),
      .stamp     (calc_left)
   );

   tcs_stamp u_stamp_right (
      .trig_time (q_head_time),
      .half_exp  (cfg.half_exp),
      .offset    (cfg.offset_right),
      .stamp     (calc_right)
   );

   assign advance = !out_valid_ff || !rsp_stall;
   assign fire = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_type_ff <= req_type;
         in_time_ff <= req_trig_time;
         in_seq_ff <= req_trig_seq;
      end
   end

   always_comb begin
      status_in = ST_STORED;
      expected_in = '0;
      head_in = '0;
      q_ctl = '0;
      next_exp_in = next_exp_ff;
      if (in_type_ff == REQ_TRIGGER) begin
         if (q_stat.full) begin
            status_in = ST_OVERFLOW;
         end else begin
            status_in = ST_STORED;
            q_ctl.push = fire;
         end
      end else begin
         expected_in = next_exp_ff;
         if (q_stat.empty) begin
            status_in = ST_NO_TRIGGER;
         end else begin
            head_in = q_head_seq;
            if (q_head_seq == next_exp_ff) begin
               status_in = ST_STAMPED;
               q_ctl.pop = fire;
            end else begin
               status_in = ST_OUT_OF_SYNC;
            end
            if (fire) begin
               next_exp_in = next_exp_ff + SEQ_W'(1);
            end
         end
      end
      stamp_left_in = (status_in == ST_STAMPED) ? calc_left : '0;
      stamp_right_in = (status_in == ST_STAMPED) ? calc_right : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_exp_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         next_exp_ff <= next_exp_in;
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff <= status_in;
         stamp_left_ff <= stamp_left_in;
         stamp_right_ff <= stamp_right_in;
         expected_ff <= expected_in;
         head_ff <= head_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_stamp_left = stamp_left_ff;
   assign rsp_stamp_right = stamp_right_ff;
   assign rsp_expected_seq = expected_ff;
   assign rsp_head_seq = head_ff;

`ifndef NO_ASSERTIONS
   a_stamp_seq_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (status_ff == ST_STAMPED)) |-> (rsp_head_seq == rsp_expected_seq))
      else $error("stamped frame with mismatched sequence");

   a_stamp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (status_ff != ST_STAMPED))
         |-> ((rsp_stamp_left == '0) && (rsp_stamp_right == '0)))
      else $error("stamp driven on a response that is not stamped");

   a_expected_advance: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (next_exp_ff != $past(next_exp_ff)))
         |-> $past(fire && (in_type_ff == REQ_FRAME) && !q_stat.empty))
      else $error("expected sequence moved without a frame");

   a_overflow: assert property (@(posedge clock) disable iff (reset)
      (fire && (in_type_ff == REQ_TRIGGER) && q_stat.full)
         |=> (rsp_valid && (status_ff == ST_OVERFLOW)))
      else $error("trigger on full queue not reported as overflow");
`endif

endmodule
